### design/rtbs_pkg.sv
// ============================================================================
// rtbs_pkg: shared types and constants of the record table bubble sorter
// Holds the record layout, the key selector codes, the datapath operation
// codes, the controller states and the command and status bundles.
// ============================================================================
package rtbs_pkg;

    // Default number of records that the table holds.
    localparam int RTBS_DEPTH_DEF = 64;

    // Width of the key selector register.
    localparam int COL_W = 3;

    // Key selector codes.
    localparam logic [COL_W-1:0] COL_DETAIL   = 3'd0;
    localparam logic [COL_W-1:0] COL_MATERIAL = 3'd1;
    localparam logic [COL_W-1:0] COL_MEASURE  = 3'd2;
    localparam logic [COL_W-1:0] COL_WORKSHOP = 3'd3;
    localparam logic [COL_W-1:0] COL_NORM     = 3'd4;
    localparam logic [COL_W-1:0] COL_NUMBER   = 3'd5;

    // Widest key is the packed measure text.
    localparam int KEY_W = 64;

    // One stored record.
    typedef struct packed {
        logic [31:0] detail_code;
        logic [31:0] material_code;
        logic [63:0] measure_text;
        logic [31:0] workshop_number;
        logic [31:0] consumption_norm;
        logic [15:0] record_number;
    } record_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_TAKE,
        OP_STEP,
        OP_FLUSH,
        OP_EMIT
    } dp_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_PASS_TAKE,
        ST_PASS_STEP,
        ST_PASS_FLUSH,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } ctrl_state_t;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        dp_op_t op;
        logic   rd_en;
        logic   emit_last;
        logic   emit_ovf;
    } ctrl_cmd_t;

    // Status bundle from the datapath to the controller.
    typedef struct packed {
        logic col_ok;
        logic out_free;
    } dp_status_t;

    // Sort key of a record under the given selector; unused codes give zero.
    function automatic logic [KEY_W-1:0] key_of(input record_t r,
                                                input logic [COL_W-1:0] col);
        logic [KEY_W-1:0] k;
        k = '0;
        case (col)
            COL_DETAIL:   k = {32'd0, r.detail_code};
            COL_MATERIAL: k = {32'd0, r.material_code};
            COL_MEASURE:  k = r.measure_text;
            COL_WORKSHOP: k = {32'd0, r.workshop_number};
            COL_NORM:     k = {32'd0, r.consumption_norm};
            COL_NUMBER:   k = {48'd0, r.record_number};
            default:      k = '0;
        endcase
        return k;
    endfunction

endpackage

### design/rtbs_dp.sv
// ============================================================================
// rtbs_dp: record table datapath
// Holds the record memory, the read data register, the carried record of a
// bubble pass with its key comparator, the key selector register and the
// output register.
// ============================================================================
module rtbs_dp
    import rtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = RTBS_DEPTH_DEF,
    localparam int ADDR_W = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [COL_W-1:0]  cfg_wdata,
    input  logic [31:0]       detail_code,
    input  logic [31:0]       material_code,
    input  logic [63:0]       measure_text,
    input  logic [31:0]       workshop_number,
    input  logic [31:0]       consumption_norm,
    input  logic [15:0]       record_number,
    input  ctrl_cmd_t         cmd,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [ADDR_W-1:0] wr_addr,
    output dp_status_t        status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_detail_code,
    output logic [31:0]       out_material_code,
    output logic [63:0]       out_measure_text,
    output logic [31:0]       out_workshop_number,
    output logic [31:0]       out_consumption_norm,
    output logic [15:0]       out_record_number,
    output logic              last_out,
    output logic              overflowed
);

    record_t          rec_mem [TABLE_DEPTH];
    record_t          rd_data_reg;
    record_t          carry_reg;
    record_t          out_rec_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [COL_W-1:0] col_reg;
    record_t          in_rec;
    record_t          wr_data;
    logic             wr_en;
    logic             carry_gt;

    // Incoming record assembled from the input ports.
    always_comb
    begin
        in_rec.detail_code      = detail_code;
        in_rec.material_code    = material_code;
        in_rec.measure_text     = measure_text;
        in_rec.workshop_number  = workshop_number;
        in_rec.consumption_norm = consumption_norm;
        in_rec.record_number    = record_number;
    end

    // Key selector register, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= COL_DETAIL;
        else if (cfg_we)
            col_reg <= cfg_wdata;
    end

    // The carried record moves on only when strictly greater, which keeps
    // equal keys in load order.
    assign carry_gt = key_of(carry_reg, col_reg) > key_of(rd_data_reg, col_reg);

    // Write port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = carry_reg;
        case (cmd.op)
            OP_LOAD_IN:
            begin
                wr_en   = 1'b1;
                wr_data = in_rec;
            end
            OP_STEP:
            begin
                wr_en   = 1'b1;
                wr_data = carry_gt ? rd_data_reg : carry_reg;
            end
            OP_FLUSH:
            begin
                wr_en   = 1'b1;
                wr_data = carry_reg;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = carry_reg;
            end
        endcase
    end

    // Record memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= rec_mem[rd_addr];
    end

    // Carried record of the current bubble pass.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TAKE)
            carry_reg <= rd_data_reg;
        else if (cmd.op == OP_STEP && !carry_gt)
            carry_reg <= rd_data_reg;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_rec_reg  <= rd_data_reg;
            out_last_reg <= cmd.emit_last;
            out_ovf_reg  <= cmd.emit_ovf;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_EMIT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.col_ok   = (col_reg <= COL_NUMBER);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid            = out_valid_reg;
    assign out_detail_code      = out_rec_reg.detail_code;
    assign out_material_code    = out_rec_reg.material_code;
    assign out_measure_text     = out_rec_reg.measure_text;
    assign out_workshop_number  = out_rec_reg.workshop_number;
    assign out_consumption_norm = out_rec_reg.consumption_norm;
    assign out_record_number    = out_rec_reg.record_number;
    assign last_out             = out_last_reg;
    assign overflowed           = out_ovf_reg;

endmodule

### design/rtbs_ctrl.sv
// ============================================================================
// rtbs_ctrl: record table controller
// Sequences loading, the bubble passes over the record memory and the
// emission of the sorted table; keeps the fill count and overflow flag.
// ============================================================================
module rtbs_ctrl
    import rtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = RTBS_DEPTH_DEF,
    localparam int ADDR_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              last_in,
    input  dp_status_t        status,
    output ctrl_cmd_t         cmd,
    output logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0] wr_addr
);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             room;
    logic             emit_last;

    assign room      = count_reg < CNT_W'(TABLE_DEPTH);
    assign emit_last = idx_reg == (count_reg - CNT_W'(1));

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        ovf_next      = ovf_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.rd_en     = 1'b0;
        cmd.emit_last = emit_last;
        cmd.emit_ovf  = ovf_reg;
        rd_addr       = idx_reg[ADDR_W-1:0];
        wr_addr       = count_reg[ADDR_W-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (room)
                    begin
                        cmd.op     = OP_LOAD_IN;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        if (count_next >= CNT_W'(2) && status.col_ok)
                        begin
                            len_next   = count_next;
                            state_next = ST_PASS_START;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_EMIT_READ;
                        end
                    end
                end
            end
            ST_PASS_START:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = '0;
                state_next = ST_PASS_TAKE;
            end
            ST_PASS_TAKE:
            begin
                cmd.op     = OP_TAKE;
                cmd.rd_en  = 1'b1;
                rd_addr    = ADDR_W'(1);
                idx_next   = CNT_W'(1);
                state_next = ST_PASS_STEP;
            end
            ST_PASS_STEP:
            begin
                // Compare the carried record with entry idx, park the smaller
                // one at idx-1 and fetch the next entry.
                cmd.op    = OP_STEP;
                cmd.rd_en = 1'b1;
                wr_addr   = ADDR_W'(idx_reg - CNT_W'(1));
                rd_addr   = ADDR_W'(idx_reg + CNT_W'(1));
                if (idx_reg == len_reg - CNT_W'(1))
                    state_next = ST_PASS_FLUSH;
                else
                    idx_next = idx_reg + CNT_W'(1);
            end
            ST_PASS_FLUSH:
            begin
                // The largest key of the pass settles at its top end.
                cmd.op   = OP_FLUSH;
                wr_addr  = ADDR_W'(len_reg - CNT_W'(1));
                len_next = len_reg - CNT_W'(1);
                if (len_next >= CNT_W'(2))
                begin
                    state_next = ST_PASS_START;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_READ;
                end
            end
            ST_EMIT_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A bubble pass always spans at least two records.
    a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS_START || state_reg == ST_PASS_STEP) |->
        (len_reg >= CNT_W'(2) && len_reg <= count_reg))
        else $error("bubble pass length out of range");

    // The compare index stays inside the current pass.
    a_step_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PASS_STEP |-> (idx_reg >= CNT_W'(1) && idx_reg < len_reg))
        else $error("compare index outside the pass");

    // A record is moved to the output only when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> status.out_free)
        else $error("output register overwritten");

    // After the final record of a run the table is empty again.
    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT && emit_last) |=> (count_reg == '0 && !ovf_reg))
        else $error("table not cleared after run");

endmodule

### design/record_table_bubble_sort_core.sv
// ============================================================================
// record_table_bubble_sort_core: loads, sorts and emits a table of records
// Input records fill a table until one marked last; the table is then
// bubble-sorted stably by the selected column and sent out in order.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) takes one record per transaction and
// is ready in every cycle of the load phase, so records may follow back to
// back. A record beyond TABLE_DEPTH is dropped and the whole run is then
// marked with overflowed. The transaction with last_in set ends the load.
// The sort then runs one bubble pass after another over the record memory,
// one compare and swap per cycle through a single read and a single write
// port; each pass carries a record up and settles the largest key at its top
// end. It is skipped for a table of one record or a key selector of 6 or 7
// (load order is kept). The output channel (out_valid/out_ready) then gives
// one transaction per record; last_out marks the final one. Each record is
// read from memory before the output register takes it. A stall on out_ready
// holds the output register and the sequencer; once the final record sits in
// the output register the next table may start loading. The user is to write
// sort_column by cfg_we/cfg_wdata while the block is idle; the block does not
// enforce it. Reset empties the table and sets sort_column to 0.
// ============================================================================
module record_table_bubble_sort_core
    import rtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = RTBS_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [COL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [31:0]      detail_code,
    input  logic [31:0]      material_code,
    input  logic [63:0]      measure_text,
    input  logic [31:0]      workshop_number,
    input  logic [31:0]      consumption_norm,
    input  logic [15:0]      record_number,
    input  logic             last_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_detail_code,
    output logic [31:0]      out_material_code,
    output logic [63:0]      out_measure_text,
    output logic [31:0]      out_workshop_number,
    output logic [31:0]      out_consumption_norm,
    output logic [15:0]      out_record_number,
    output logic             last_out,
    output logic             overflowed
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Sequencer.
    rtbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last_in  (last_in),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    // Record storage, comparator and output register.
    rtbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .detail_code          (detail_code),
        .material_code        (material_code),
        .measure_text         (measure_text),
        .workshop_number      (workshop_number),
        .consumption_norm     (consumption_norm),
        .record_number        (record_number),
        .cmd                  (cmd),
        .rd_addr              (rd_addr),
        .wr_addr              (wr_addr),
        .status               (status),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .out_detail_code      (out_detail_code),
        .out_material_code    (out_material_code),
        .out_measure_text     (out_measure_text),
        .out_workshop_number  (out_workshop_number),
        .out_consumption_norm (out_consumption_norm),
        .out_record_number    (out_record_number),
        .last_out             (last_out),
        .overflowed           (overflowed)
    );

endmodule
